// ===== hw/rtl/rgb_bevel_edge_shader_assert.svh =====
// Assertion macros shared by the checker.
`ifndef RGB_BEVEL_EDGE_SHADER_ASSERT_SVH
`define RGB_BEVEL_EDGE_SHADER_ASSERT_SVH

// Check on every clock edge outside reset.
`define RBES_ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define RBES_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rbes_pkg.sv =====
package rbes_pkg;

  // Image limits and field widths
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int DIM_W      = 13;
  localparam int CNT_W      = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
  localparam int CHAN_W     = 8;
  localparam int MODE_W     = 2;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;
  localparam int IDX_W      = PADDR_W - 2;

  // Shading constants
  localparam logic [CHAN_W-1:0] LIGHT_LIMIT = CHAN_W'(175);
  localparam logic [CHAN_W-1:0] LIGHT_STEP  = CHAN_W'(80);
  localparam logic [CHAN_W-1:0] DARK_STEP   = CHAN_W'(40);
  localparam logic [CHAN_W-1:0] CHAN_MAX    = CHAN_W'(255);

  // Register map
  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SUNKEN        = 2'd0,
    MODE_RAISED        = 2'd1,
    MODE_RAISED_OUTER  = 2'd2,
    MODE_RAISED_DOUBLE = 2'd3
  } bevel_mode_t;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(64);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(64);

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    bevel_mode_t      mode;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // Where the pixel stands relative to the border
  typedef struct packed {
    logic tiny;          // image below 3 by 3, pass through
    logic y_first;
    logic y_second;
    logic y_below_first;
    logic x_first;
    logic x_second;
    logic y_last;
    logic y_next_last;
    logic x_inner;       // 1 <= x <= w-2
    logic x_next_last;
    logic x_last;
  } pos_t;

  typedef struct packed {
    pixel_t pix;
    pos_t   pos;
    logic   eoi;
  } stage_t;

  function automatic logic [CHAN_W-1:0] lighten(input logic [CHAN_W-1:0] c);
    return (c < LIGHT_LIMIT) ? c + LIGHT_STEP : CHAN_MAX;
  endfunction

  function automatic logic [CHAN_W-1:0] darken(input logic [CHAN_W-1:0] c);
    return (c > DARK_STEP) ? c - DARK_STEP : '0;
  endfunction

  function automatic logic [CHAN_W-1:0] light_or_dark(input logic [CHAN_W-1:0] c,
                                                      input logic light);
    return light ? lighten(c) : darken(c);
  endfunction

  // Zero acts as one, oversize saturates
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] d;
    if (v == '0) d = DIM_W'(1);
    else if (v > maxv) d = maxv;
    else d = v;
    return d;
  endfunction

  // Apply top, left, bottom, right edges in that order
  function automatic logic [CHAN_W-1:0] shade_chan(input logic [CHAN_W-1:0] c,
                                                   input pos_t p,
                                                   input bevel_mode_t m);
    logic raised;
    logic outer;
    logic dbl;
    logic [CHAN_W-1:0] v;
    raised = (m != MODE_SUNKEN);
    outer  = (m == MODE_RAISED_OUTER) || (m == MODE_RAISED_DOUBLE);
    dbl    = (m == MODE_RAISED_DOUBLE);
    v = c;
    if (!p.tiny) begin
      if (p.y_first || (dbl && p.y_second)) v = light_or_dark(v, raised);
      if (p.y_below_first && (p.x_first || (dbl && p.x_second)))
        v = light_or_dark(v, raised);
      if (outer) begin
        if (p.y_last) v = '0;
        else if (p.y_next_last && p.x_inner) v = darken(v);
      end else if (p.y_last) begin
        v = light_or_dark(v, !raised);
      end
      if (!p.y_last) begin
        if (outer) begin
          if (p.x_next_last) v = darken(v);
          else if (p.x_last) v = '0;
        end else if (p.x_last) begin
          v = light_or_dark(v, !raised);
        end
      end
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/rbes_in_if.sv =====
interface rbes_in_if import rbes_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                output ready);
endinterface

// ===== hw/rtl/rbes_out_if.sv =====
interface rbes_out_if import rbes_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic              end_of_image;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output end_of_image, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input end_of_image, output ready);
endinterface

// ===== hw/rtl/rbes_cfg_regs.sv =====
module rbes_cfg_regs import rbes_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  bevel_mode_t      mode_r;
  logic             wr_en;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      mode_r   <= MODE_RAISED;
    end else if (wr_en) begin
      case (idx)
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        REG_MODE:   mode_r   <= bevel_mode_t'(pwdata[MODE_W-1:0]);
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = PDATA_W'(width_r);
      REG_HEIGHT: prdata = PDATA_W'(height_r);
      REG_MODE:   prdata = PDATA_W'(mode_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.width  = width_r;
  assign cfg.height = height_r;
  assign cfg.mode   = mode_r;

endmodule

// ===== hw/rtl/rbes_locate.sv =====
module rbes_locate import rbes_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   in_valid,
  output logic   in_ready,
  input  pixel_t in_pix,
  input  logic   adv,
  output logic   s1_valid,
  output stage_t s1_data
);

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic             s1_v_r, s1_v_nxt;
  stage_t           s1_r;
  logic [DIM_W-1:0] w, h, wm1, hm1, wm2, hm2;
  logic             last_col, last_row, acc;
  logic [CNT_W-1:0] x, y;
  pos_t             pos;

  // Effective dimensions
  assign w   = eff_dim(cfg.width, DIM_W'(MAX_WIDTH));
  assign h   = eff_dim(cfg.height, DIM_W'(MAX_HEIGHT));
  assign wm1 = w - DIM_W'(1);
  assign hm1 = h - DIM_W'(1);
  assign wm2 = w - DIM_W'(2);
  assign hm2 = h - DIM_W'(2);

  // Clamp counters into the image
  assign last_col = {1'b0, col_r} >= wm1;
  assign last_row = {1'b0, row_r} >= hm1;
  assign x = last_col ? wm1[CNT_W-1:0] : col_r;
  assign y = last_row ? hm1[CNT_W-1:0] : row_r;

  always_comb begin
    pos.tiny          = (w < DIM_W'(3)) || (h < DIM_W'(3));
    pos.y_first       = (y == '0);
    pos.y_second      = (y == CNT_W'(1));
    pos.y_below_first = (y != '0);
    pos.x_first       = (x == '0);
    pos.x_second      = (x == CNT_W'(1));
    pos.y_last        = last_row;
    pos.y_next_last   = ({1'b0, y} == hm2);
    pos.x_inner       = (x != '0) && ({1'b0, x} <= wm2);
    pos.x_next_last   = ({1'b0, x} == wm2);
    pos.x_last        = last_col;
  end

  assign in_ready = !s1_v_r || adv;
  assign acc      = in_valid && in_ready;

  // Advance raster counters on each accepted word
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  assign s1_v_nxt = in_ready ? in_valid : s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r.pix <= in_pix;
      s1_r.pos <= pos;
      s1_r.eoi <= last_col && last_row;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_data  = s1_r;

endmodule

// ===== hw/rtl/rbes_shade.sv =====
module rbes_shade import rbes_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   s1_valid,
  input  stage_t s1_data,
  output logic   adv,
  output logic   out_valid,
  input  logic   out_ready,
  output pixel_t out_pix,
  output logic   out_eoi
);

  logic   s2_v_r;
  pixel_t pix_r;
  logic   eoi_r;
  pixel_t shaded;

  // Shade each channel alike
  always_comb begin
    shaded.red   = shade_chan(s1_data.pix.red,   s1_data.pos, cfg.mode);
    shaded.green = shade_chan(s1_data.pix.green, s1_data.pos, cfg.mode);
    shaded.blue  = shade_chan(s1_data.pix.blue,  s1_data.pos, cfg.mode);
  end

  assign adv = !s2_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_valid;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      pix_r <= shaded;
      eoi_r <= s1_data.eoi;
    end
  end

  assign out_valid = s2_v_r;
  assign out_pix   = pix_r;
  assign out_eoi   = eoi_r;

endmodule

// ===== hw/rtl/rgb_bevel_edge_shader.sv =====
// Channel   Direction  Words
// in_pix    sink       red_in, green_in, blue_in (raster order)
// out_pix   source     red_out, green_out, blue_out, end_of_image
// cfg (APB) slave      image_width @0x0, image_height @0x4, bevel_mode @0x8
//
// One pixel per clock sustained while the output is ready; an accepted pixel
// passes through the input register and then the result register, with the
// per-channel shading logic between them.
// rst_n is synchronous: counters return to the first pixel, config registers to defaults.
// A stalled output holds its word; the input keeps accepting while a slot is free.
module rgb_bevel_edge_shader import rbes_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  rbes_in_if.sink            in_pix,
  rbes_out_if.source         out_pix,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t   cfg;
  pixel_t in_word;
  pixel_t out_word;
  stage_t s1_data;
  logic   s1_valid;
  logic   adv;

  rbes_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_word.red   = in_pix.red_in;
  assign in_word.green = in_pix.green_in;
  assign in_word.blue  = in_pix.blue_in;

  rbes_locate u_locate (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_pix.valid),
    .in_ready (in_pix.ready),
    .in_pix   (in_word),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  rbes_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_data   (s1_data),
    .adv       (adv),
    .out_valid (out_pix.valid),
    .out_ready (out_pix.ready),
    .out_pix   (out_word),
    .out_eoi   (out_pix.end_of_image)
  );

  assign out_pix.red_out   = out_word.red;
  assign out_pix.green_out = out_word.green;
  assign out_pix.blue_out  = out_word.blue;

endmodule

// ===== hw/rtl/rbes_checker.sv =====
`include "rgb_bevel_edge_shader_assert.svh"

module rbes_checker import rbes_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAN_W-1:0] out_red,
  input logic [CHAN_W-1:0] out_green,
  input logic [CHAN_W-1:0] out_blue,
  input logic              out_eoi
);

  // A stalled result word holds
  `RBES_ASSERT_ON(a_out_hold, (out_valid && !out_ready |=> out_valid && $stable({out_red, out_green, out_blue, out_eoi})), "stalled output word changed")

  // Reset empties the result register
  `RBES_ASSERT_ALWAYS(a_rst_empty, (!rst_n |=> !out_valid), "output valid after reset")

  // A draining output never blocks the input
  `RBES_ASSERT_ALWAYS(a_no_bubble, (out_ready |-> in_ready), "input stalled while output drains")

  // A new result follows an accepted word through the input and result registers
  `RBES_ASSERT_ON(a_origin, ($rose(out_valid) |-> $past(in_valid && in_ready, 2)), "result without accepted word")

endmodule

bind rgb_bevel_edge_shader rbes_checker u_rbes_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .out_red   (out_pix.red_out),
  .out_green (out_pix.green_out),
  .out_blue  (out_pix.blue_out),
  .out_eoi   (out_pix.end_of_image)
);
